FILE: rtl/core/sdzd_pkg.sv
package sdzd_pkg;

   localparam int COORD_BITS_DEF = 10;

   localparam int RADIUS_W  = 9;
   localparam int BTN_W     = 32;
   localparam int BTN_KEEP_W = 28;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_INNER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUTER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DOWN  = 3'd5;

   localparam logic [RADIUS_W-1:0] INNER_RST = 9'd40;
   localparam logic [RADIUS_W-1:0] OUTER_RST = 9'd145;
   localparam logic [BTN_W-1:0] LEFT_RST  = 32'h2000_0000;
   localparam logic [BTN_W-1:0] RIGHT_RST = 32'h1000_0000;
   localparam logic [BTN_W-1:0] UP_RST    = 32'h4000_0000;
   localparam logic [BTN_W-1:0] DOWN_RST  = 32'h8000_0000;

   // Squared radii are held at this width.
   localparam int RSQ_W = 2 * RADIUS_W;

   localparam int TAN_LIMIT   = 443;
   localparam int SQRT_SHIFT  = 14;
   localparam int SCALE_SHIFT = 7;

endpackage

FILE: rtl/core/sdzd_sqrt.sv
module sdzd_sqrt #(
   parameter int NW = 34,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NW-1:0]     in_n,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NW/2-1:0]   out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int RB  = NW / 2;
   localparam int RMW = RB + 2;
   localparam int CW  = RB + 4;

   logic [RMW-1:0]    rem_ff  [RB];
   logic [RB-1:0]     root_ff [RB];
   logic [NW-1:0]     n_ff    [RB];
   logic [SIDE_W-1:0] side_ff [RB];
   logic [RB-1:0]     vld_ff;

   logic [RMW-1:0]    rem_in  [RB];
   logic [RB-1:0]     root_in [RB];
   logic [NW-1:0]     n_in    [RB];
   logic [SIDE_W-1:0] side_in [RB];
   logic [RB-1:0]     vld_in;

   // One root bit per stage: bring down two radicand bits and try root*4+1.
   always_comb begin
      logic [RMW-1:0] rem_p;
      logic [RB-1:0]  root_p;
      logic [NW-1:0]  n_p;
      logic [CW-1:0]  cur;
      logic [CW-1:0]  trial;
      for (int k = 0; k < RB; k++) begin
         if (k == 0) begin
            rem_p      = '0;
            root_p     = '0;
            n_p        = in_n;
            side_in[k] = in_side;
            vld_in[k]  = in_valid;
         end else begin
            rem_p      = rem_ff[k-1];
            root_p     = root_ff[k-1];
            n_p        = n_ff[k-1];
            side_in[k] = side_ff[k-1];
            vld_in[k]  = vld_ff[k-1];
         end
         cur   = {rem_p, n_p[NW-1 -: 2]};
         trial = {2'b00, root_p, 2'b01};
         if (cur >= trial) begin
            rem_in[k]  = RMW'(cur - trial);
            root_in[k] = {root_p[RB-2:0], 1'b1};
         end else begin
            rem_in[k]  = RMW'(cur);
            root_in[k] = {root_p[RB-2:0], 1'b0};
         end
         n_in[k] = {n_p[NW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < RB; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            n_ff[k]    <= n_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = vld_ff[RB-1];
   assign out_root  = root_ff[RB-1];
   assign out_side  = side_ff[RB-1];

endmodule

FILE: rtl/core/sdzd_div.sv
module sdzd_div #(
   parameter int DW = 28,
   parameter int VW = 17,
   parameter int QW = 10,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DW-1:0]     in_a,
   input  logic [DW-1:0]     in_b,
   input  logic [VW-1:0]     in_d,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QW-1:0]     out_qa,
   output logic [QW-1:0]     out_qb,
   output logic [SIDE_W-1:0] out_side
);

   logic [DW-1:0]     ra_ff   [QW];
   logic [DW-1:0]     rb_ff   [QW];
   logic [VW-1:0]     d_ff    [QW];
   logic [QW-1:0]     qa_ff   [QW];
   logic [QW-1:0]     qb_ff   [QW];
   logic [SIDE_W-1:0] side_ff [QW];
   logic [QW-1:0]     vld_ff;

   logic [DW-1:0]     ra_in   [QW];
   logic [DW-1:0]     rb_in   [QW];
   logic [VW-1:0]     d_in    [QW];
   logic [QW-1:0]     qa_in   [QW];
   logic [QW-1:0]     qb_in   [QW];
   logic [SIDE_W-1:0] side_in [QW];
   logic [QW-1:0]     vld_in;

   // Restoring division, both dividends share the divisor; the quotient
   // is known to fit in QW bits so the first stage tests bit QW-1.
   always_comb begin
      logic [DW-1:0] ra_p;
      logic [DW-1:0] rb_p;
      logic [QW-1:0] qa_p;
      logic [QW-1:0] qb_p;
      logic [DW-1:0] dsh;
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            ra_p       = in_a;
            rb_p       = in_b;
            qa_p       = '0;
            qb_p       = '0;
            d_in[k]    = in_d;
            side_in[k] = in_side;
            vld_in[k]  = in_valid;
         end else begin
            ra_p       = ra_ff[k-1];
            rb_p       = rb_ff[k-1];
            qa_p       = qa_ff[k-1];
            qb_p       = qb_ff[k-1];
            d_in[k]    = d_ff[k-1];
            side_in[k] = side_ff[k-1];
            vld_in[k]  = vld_ff[k-1];
         end
         dsh = DW'(d_in[k]) << (QW - 1 - k);
         if (ra_p >= dsh) begin
            ra_in[k] = ra_p - dsh;
            qa_in[k] = {qa_p[QW-2:0], 1'b1};
         end else begin
            ra_in[k] = ra_p;
            qa_in[k] = {qa_p[QW-2:0], 1'b0};
         end
         if (rb_p >= dsh) begin
            rb_in[k] = rb_p - dsh;
            qb_in[k] = {qb_p[QW-2:0], 1'b1};
         end else begin
            rb_in[k] = rb_p;
            qb_in[k] = {qb_p[QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QW; k++) begin
            ra_ff[k]   <= ra_in[k];
            rb_ff[k]   <= rb_in[k];
            d_ff[k]    <= d_in[k];
            qa_ff[k]   <= qa_in[k];
            qb_ff[k]   <= qb_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_qa    = qa_ff[QW-1];
   assign out_qb    = qb_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

FILE: rtl/core/stick_dead_zone_to_dpad.sv
// Pipeline from an accepted transaction to its result: two input stages, one stage
// per root bit of the square root, two scaling stages, one stage per quotient bit,
// one output stage.
// Throughput: one transaction per cycle; the whole pipeline holds while a result waits.
// Reset clears all valid bits and loads the register defaults.
module stick_dead_zone_to_dpad
   import sdzd_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // pad_x, pad_y, buttons_in; zero filled to whole bytes
   input  logic [((2*COORD_BITS+BTN_W+7)/8)*8-1:0] req_tdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // buttons_out, adjusted_x, adjusted_y; zero filled to whole bytes
   output logic [((2*COORD_BITS+BTN_W+7)/8)*8-1:0] rsp_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int CB    = COORD_BITS;
   localparam int PW    = ((2*CB+BTN_W+7)/8)*8;
   localparam int R2W   = 2 * CB;
   localparam int SQW   = (R2W > RSQ_W) ? R2W : RSQ_W;
   localparam int NW    = R2W + SQRT_SHIFT;
   localparam int RB    = NW / 2;
   localparam int NUMW  = CB + 10;
   localparam int MAGW  = CB + 8;
   localparam int DW    = CB + MAGW;
   localparam int TW    = CB + 10;
   localparam int SIDE1 = 2*CB + BTN_KEEP_W + 2;
   localparam int SIDE2 = BTN_KEEP_W + 3;

   logic en;

   // Configuration registers.
   logic [RADIUS_W-1:0] inner_ff, outer_ff;
   logic [BTN_W-1:0]    left_ff, right_ff, up_ff, down_ff;
   logic [RSQ_W-1:0]    in2_ff, out2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= INNER_RST;
         outer_ff <= OUTER_RST;
         left_ff  <= LEFT_RST;
         right_ff <= RIGHT_RST;
         up_ff    <= UP_RST;
         down_ff  <= DOWN_RST;
         in2_ff   <= RSQ_W'(INNER_RST) * RSQ_W'(INNER_RST);
         out2_ff  <= RSQ_W'(OUTER_RST) * RSQ_W'(OUTER_RST);
      end else begin
         in2_ff  <= RSQ_W'(inner_ff) * RSQ_W'(inner_ff);
         out2_ff <= RSQ_W'(outer_ff) * RSQ_W'(outer_ff);
         if (csr_wen) begin
            unique case (csr_index)
               REG_INNER: inner_ff <= csr_wdata[RADIUS_W-1:0];
               REG_OUTER: outer_ff <= csr_wdata[RADIUS_W-1:0];
               REG_LEFT:  left_ff  <= csr_wdata[BTN_W-1:0];
               REG_RIGHT: right_ff <= csr_wdata[BTN_W-1:0];
               REG_UP:    up_ff    <= csr_wdata[BTN_W-1:0];
               REG_DOWN:  down_ff  <= csr_wdata[BTN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Stage 0: squares of the axes.
   logic signed [R2W-1:0] xe, ye;
   logic                  s0_vld_ff;
   logic [CB-1:0]         s0_x_ff, s0_y_ff;
   logic [BTN_KEEP_W-1:0] s0_btn_ff;
   logic [R2W-1:0]        s0_xx_ff, s0_yy_ff;

   assign xe = R2W'(signed'(req_tdata[CB-1:0]));
   assign ye = R2W'(signed'(req_tdata[2*CB-1:CB]));

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_x_ff   <= req_tdata[CB-1:0];
         s0_y_ff   <= req_tdata[2*CB-1:CB];
         s0_btn_ff <= req_tdata[2*CB+BTN_KEEP_W-1:2*CB];
         s0_xx_ff  <= unsigned'(xe * xe);
         s0_yy_ff  <= unsigned'(ye * ye);
      end
   end

   // Stage 1: radius squared against both thresholds.
   logic [R2W-1:0]        r2_in;
   logic                  dead_in, sat_in;
   logic                  s1_vld_ff, s1_dead_ff, s1_sat_ff;
   logic [CB-1:0]         s1_x_ff, s1_y_ff;
   logic [BTN_KEEP_W-1:0] s1_btn_ff;
   logic [R2W-1:0]        s1_r2_ff;

   assign r2_in   = s0_xx_ff + s0_yy_ff;
   assign dead_in = !(SQW'(r2_in) > SQW'(in2_ff));
   assign sat_in  = SQW'(r2_in) >= SQW'(out2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff    <= s0_x_ff;
         s1_y_ff    <= s0_y_ff;
         s1_btn_ff  <= s0_btn_ff;
         s1_r2_ff   <= r2_in;
         s1_dead_ff <= dead_in;
         s1_sat_ff  <= sat_in;
      end
   end

   // Length in 1/128 units: floor(sqrt(r2 << 14)).
   logic              sq_vld;
   logic [RB-1:0]     sq_root;
   logic [SIDE1-1:0]  sq_side;

   sdzd_sqrt #(
      .NW     (NW),
      .SIDE_W (SIDE1)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_vld_ff),
      .in_n      ({s1_r2_ff, {SQRT_SHIFT{1'b0}}}),
      .in_side   ({s1_sat_ff, s1_dead_ff, s1_btn_ff, s1_y_ff, s1_x_ff}),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   logic [CB-1:0]         sq_x, sq_y;
   logic [BTN_KEEP_W-1:0] sq_btn;
   logic                  sq_dead, sq_sat;

   assign sq_x    = sq_side[CB-1:0];
   assign sq_y    = sq_side[2*CB-1:CB];
   assign sq_btn  = sq_side[2*CB+BTN_KEEP_W-1:2*CB];
   assign sq_dead = sq_side[2*CB+BTN_KEEP_W];
   assign sq_sat  = sq_side[2*CB+BTN_KEEP_W+1];

   // Stage 2: numerator of the scale factor, as sign and magnitude.
   logic signed [NUMW-1:0] inner_s, outer_s, root_s, num_in, nabs;
   logic                   s2_vld_ff, s2_neg_ff, s2_dead_ff;
   logic [MAGW-1:0]        s2_mag_ff;
   logic [RB-1:0]          s2_len_ff;
   logic [CB-1:0]          s2_x_ff, s2_y_ff;
   logic [BTN_KEEP_W-1:0]  s2_btn_ff;

   assign inner_s = signed'(NUMW'({inner_ff, {SCALE_SHIFT{1'b0}}}));
   assign outer_s = signed'(NUMW'({outer_ff, {SCALE_SHIFT{1'b0}}}));
   assign root_s  = signed'(NUMW'(sq_root));
   assign num_in  = sq_sat ? (outer_s - inner_s) : (root_s - inner_s);
   assign nabs    = num_in[NUMW-1] ? -num_in : num_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_mag_ff  <= nabs[MAGW-1:0];
         s2_neg_ff  <= num_in[NUMW-1];
         s2_len_ff  <= sq_root;
         s2_x_ff    <= sq_x;
         s2_y_ff    <= sq_y;
         s2_btn_ff  <= sq_btn;
         s2_dead_ff <= sq_dead;
      end
   end

   // Stage 3: axis magnitude times numerator magnitude.
   logic [CB-1:0]         xm, ym;
   logic                  s3_vld_ff, s3_sx_ff, s3_sy_ff, s3_dead_ff;
   logic [DW-1:0]         s3_pa_ff, s3_pb_ff;
   logic [RB-1:0]         s3_len_ff;
   logic [BTN_KEEP_W-1:0] s3_btn_ff;

   assign xm = s2_x_ff[CB-1] ? -s2_x_ff : s2_x_ff;
   assign ym = s2_y_ff[CB-1] ? -s2_y_ff : s2_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_pa_ff   <= DW'(xm) * DW'(s2_mag_ff);
         s3_pb_ff   <= DW'(ym) * DW'(s2_mag_ff);
         s3_sx_ff   <= s2_x_ff[CB-1] ^ s2_neg_ff;
         s3_sy_ff   <= s2_y_ff[CB-1] ^ s2_neg_ff;
         s3_len_ff  <= s2_len_ff;
         s3_btn_ff  <= s2_btn_ff;
         s3_dead_ff <= s2_dead_ff;
      end
   end

   logic              dv_vld;
   logic [CB-1:0]     dv_qa, dv_qb;
   logic [SIDE2-1:0]  dv_side;

   sdzd_div #(
      .DW     (DW),
      .VW     (RB),
      .QW     (CB),
      .SIDE_W (SIDE2)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_vld_ff),
      .in_a      (s3_pa_ff),
      .in_b      (s3_pb_ff),
      .in_d      (s3_len_ff),
      .in_side   ({s3_btn_ff, s3_dead_ff, s3_sy_ff, s3_sx_ff}),
      .out_valid (dv_vld),
      .out_qa    (dv_qa),
      .out_qb    (dv_qb),
      .out_side  (dv_side)
   );

   // Stage 4: signs, dead zone, direction test and button masks.
   logic          dv_sx, dv_sy, dv_dead;
   logic [CB-1:0] qa, qb, ax_in, ay_in;
   logic          tan_x_ok, tan_y_ok;
   logic [BTN_W-1:0] btn_in;
   logic             s4_vld_ff;
   logic [BTN_W-1:0] s4_btn_ff;
   logic [CB-1:0]    s4_ax_ff, s4_ay_ff;

   assign dv_sx   = dv_side[0];
   assign dv_sy   = dv_side[1];
   assign dv_dead = dv_side[2];
   assign qa      = dv_dead ? '0 : dv_qa;
   assign qb      = dv_dead ? '0 : dv_qb;

   // |tan| <= 443 in 8.8 with truncation is the same as other*256 < 444*axis.
   assign tan_x_ok = (TW'(qb) << 8) < (TW'(qa) * TW'(TAN_LIMIT + 1));
   assign tan_y_ok = (TW'(qa) << 8) < (TW'(qb) * TW'(TAN_LIMIT + 1));

   assign ax_in = dv_sx ? -qa : qa;
   assign ay_in = dv_sy ? -qb : qb;

   always_comb begin
      btn_in = BTN_W'(dv_side[SIDE2-1:3]);
      if (qa != '0 && tan_x_ok) begin
         btn_in = btn_in | (dv_sx ? left_ff : right_ff);
      end
      if (qb != '0 && tan_y_ok) begin
         btn_in = btn_in | (dv_sy ? down_ff : up_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_btn_ff <= btn_in;
         s4_ax_ff  <= ax_in;
         s4_ay_ff  <= ay_in;
      end
   end

   assign en         = !s4_vld_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = s4_vld_ff;
   assign rsp_tdata  = PW'({s4_ay_ff, s4_ax_ff, s4_btn_ff});

   a_reset_empties : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Leaving the dead zone means r2 >= 1, so the length is at least 128.
   a_len_min : assert property (@(posedge clock) disable iff (reset)
      sq_vld && !sq_dead |-> sq_root[RB-1:SCALE_SHIFT] != '0)
      else $error("square root below 128 outside the dead zone");

   // No direction mask can apply when both axes come out zero.
   a_no_mask_at_center : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && s4_ax_ff == '0 && s4_ay_ff == '0 |->
         s4_btn_ff[BTN_W-1:BTN_KEEP_W] == '0)
      else $error("direction bits set with centered stick");

endmodule

FILE: sim/stick_dead_zone_to_dpad_test.sv
module stick_dead_zone_to_dpad_test;
   import sdzd_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int DW = ((2*CB+BTN_W+7)/8)*8;
   localparam int DRAIN_CYCLES = 2*CB + 24;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   // pad_x, pad_y, buttons_in from the lowest bit up
   logic [DW-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // buttons_out, adjusted_x, adjusted_y from the lowest bit up
   logic [DW-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   // Local copy of the block's registers.
   logic [RADIUS_W-1:0] inner_r, outer_r;
   logic [BTN_W-1:0] mask_left, mask_right, mask_up, mask_down;

   logic [DW-1:0] pending_rsp[$];
   int send_idle = 0;
   int recv_idle = 0;
   int errors = 0;
   int sent = 0;
   int checked = 0;
   int cycles = 0;
   int config_count = 0;

   stick_dead_zone_to_dpad dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic bit within_60deg(longint other, longint axis);
      longint t;
      t = (other * 256) / axis;
      return (t >= -TAN_LIMIT) && (t <= TAN_LIMIT);
   endfunction

   function automatic logic [DW-1:0] dead_zone_dpad(logic [DW-1:0] word);
      longint x, y, r2, in2, out2, len, num, ax, ay;
      logic [BTN_W-1:0] btn;
      logic [DW-1:0] res;
      x = longint'($signed(word[CB-1:0]));
      y = longint'($signed(word[2*CB-1:CB]));
      btn = {4'b0, word[2*CB+BTN_KEEP_W-1:2*CB]};
      ax = 0;
      ay = 0;
      r2 = x*x + y*y;
      in2 = longint'(inner_r) * longint'(inner_r);
      out2 = longint'(outer_r) * longint'(outer_r);
      if (r2 > in2) begin
         len = longint'(root_floor(longint'(r2) << SQRT_SHIFT));
         if (r2 >= out2) num = (longint'(outer_r) - longint'(inner_r)) * 128;
         else num = len - longint'(inner_r) * 128;
         ax = (x * num) / len;
         ay = (y * num) / len;
      end
      if (ax > 0 && within_60deg(ay, ax)) btn = btn | mask_right;
      else if (ax < 0 && within_60deg(ay, ax)) btn = btn | mask_left;
      if (ay > 0 && within_60deg(ax, ay)) btn = btn | mask_up;
      else if (ay < 0 && within_60deg(ax, ay)) btn = btn | mask_down;
      res = '0;
      res[BTN_W-1:0] = btn;
      res[BTN_W+CB-1:BTN_W] = ax[CB-1:0];
      res[BTN_W+2*CB-1:BTN_W+CB] = ay[CB-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on result %0d: %s got %h expected %h", checked, what, got, want);
      errors++;
   endtask

   // Outputs settle between edges; sampling at the falling edge avoids races.
   always @(negedge clock) begin
      logic [DW-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata[BTN_W-1:0] !== want[BTN_W-1:0])
               report_mismatch("buttons_out", rsp_tdata[BTN_W-1:0], want[BTN_W-1:0]);
            if (rsp_tdata[BTN_W+CB-1:BTN_W] !== want[BTN_W+CB-1:BTN_W])
               report_mismatch("adjusted_x", rsp_tdata[BTN_W+CB-1:BTN_W],
                               want[BTN_W+CB-1:BTN_W]);
            if (rsp_tdata[BTN_W+2*CB-1:BTN_W+CB] !== want[BTN_W+2*CB-1:BTN_W+CB])
               report_mismatch("adjusted_y", rsp_tdata[BTN_W+2*CB-1:BTN_W+CB],
                               want[BTN_W+2*CB-1:BTN_W+CB]);
         end
         checked++;
      end
   end

   task automatic send_sample(int x, int y, logic [BTN_W-1:0] btn);
      logic [DW-1:0] word;
      bit taken;
      word = '0;
      word[CB-1:0] = x[CB-1:0];
      word[2*CB-1:CB] = y[CB-1:0];
      word[2*CB+BTN_W-1:2*CB] = btn;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      pending_rsp.push_back(dead_zone_dpad(word));
      sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The enable drops after each write so that back to back writes never
   // assign it twice at the same edge.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_INNER: inner_r = value[RADIUS_W-1:0];
         REG_OUTER: outer_r = value[RADIUS_W-1:0];
         REG_LEFT:  mask_left = value;
         REG_RIGHT: mask_right = value;
         REG_UP:    mask_up = value;
         REG_DOWN:  mask_down = value;
         default: ;
      endcase
      config_count++;
   endtask

   task automatic set_radii(logic [CSR_W-1:0] inner, logic [CSR_W-1:0] outer);
      write_reg(REG_INNER, inner);
      write_reg(REG_OUTER, outer);
   endtask

   task automatic set_masks(logic [BTN_W-1:0] l, logic [BTN_W-1:0] r,
                            logic [BTN_W-1:0] u, logic [BTN_W-1:0] d);
      write_reg(REG_LEFT, l);
      write_reg(REG_RIGHT, r);
      write_reg(REG_UP, u);
      write_reg(REG_DOWN, d);
   endtask

   task automatic test_reset_defaults;
      send_sample(0, 0, 32'hFFFF_FFFF);
      send_sample(40, 0, 32'h0);          // exactly on the dead zone edge
      send_sample(41, 0, 32'h0);
      send_sample(0, -41, 32'h0FFF_FFFF);
      send_sample(145, 0, 32'h0);
      send_sample(511, 511, 32'hA5A5_A5A5);
      send_sample(-512, -512, 32'h5A5A_5A5A);
      send_sample(-512, 511, 32'h0);
      send_sample(100, 60, 32'h0);        // near the 60 degree boundary
      send_sample(60, -100, 32'h0);
      drain();
   endtask

   task automatic test_no_dead_zone;
      set_radii(0, 511);
      set_masks(32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'hF000_0000);
      send_sample(-512, 0, 32'h0);        // full negative axis
      send_sample(0, -512, 32'h0);
      send_sample(1, 0, 32'h0);
      send_sample(0, 1, 32'h0);
      send_sample(511, -512, 32'hFFFF_FFFF);
      send_sample(-1, -1, 32'h0);
      drain();
   endtask

   task automatic test_inverted_radii;
      // Outer below inner: the deflection flips sign.
      set_radii(32'hFFFF_FE1F, 5);
      set_masks(32'h1, 32'h2, 32'h4, 32'h8);
      send_sample(-512, 0, 32'h0);
      send_sample(511, 511, 32'h0);
      send_sample(-400, 300, 32'h0);
      send_sample(200, -511, 32'h0);
      send_sample(511, 0, 32'h0);
      drain();
   endtask

   task automatic test_random_samples(int count);
      int x, y, r, m;
      repeat (count) begin
         m = $urandom_range(3);
         if (m == 0) begin
            x = $urandom_range(1023) - 512;
            y = $urandom_range(1023) - 512;
         end else if (m == 1) begin
            // Land close to one of the configured radii.
            r = ($urandom_range(1) ? inner_r : outer_r) + $urandom_range(6) - 3;
            x = $urandom_range(r < 0 ? 0 : r);
            y = int'(root_floor(longint'(r*r > x*x ? r*r - x*x : 0)));
            if ($urandom_range(1)) x = -x;
            if ($urandom_range(1)) y = -y;
            if (x > 511) x = 511;
            if (y > 511) y = 511;
            if (x < -512) x = -512;
            if (y < -512) y = -512;
         end else if (m == 2) begin
            x = $urandom_range(40) - 20;
            y = $urandom_range(1023) - 512;
            if ($urandom_range(1)) begin r = x; x = y; y = r; end
         end else begin
            x = $urandom_range(1) ? 511 : -512;
            y = $urandom_range(1023) - 512;
         end
         send_sample(x, y, $urandom);
      end
      drain();
   endtask

   task automatic test_random_settings(int count);
      set_radii(40, 145);
      set_masks(LEFT_RST, RIGHT_RST, UP_RST, DOWN_RST);
      test_random_samples(count);
      set_radii($urandom_range(200), $urandom_range(511));
      set_masks($urandom, $urandom, $urandom, $urandom);
      test_random_samples(count);
      set_radii(511, 511);
      set_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      test_random_samples(count);
      set_radii($urandom_range(511), $urandom_range(100));
      set_masks(32'h0, 32'h0, 32'h0, 32'h0);
      test_random_samples(count);
   endtask

   initial begin
      inner_r = INNER_RST;
      outer_r = OUTER_RST;
      mask_left = LEFT_RST;
      mask_right = RIGHT_RST;
      mask_up = UP_RST;
      mask_down = DOWN_RST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle = 16;
      recv_idle = 55;
      test_reset_defaults();
      test_no_dead_zone();
      test_inverted_radii();
      test_random_settings(155);
      send_idle = 55;
      recv_idle = 16;
      test_random_settings(155);
      send_idle = 0;
      recv_idle = 0;
      test_random_settings(155);
      $display("sent %0d stick samples, checked %0d results, %0d register writes",
               sent, checked, config_count);
      $display("covered dead zone edges, saturation, inverted radii and mask settings");
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, pending_rsp.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule
